// File: src/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define CLNW_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every rising edge, reset included.
`define CLNW_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/clnw_pkg.sv
// Shared types and constants of the character LCD nibble writer.
`timescale 1ns / 1ps
package clnw_pkg;

  localparam int MAX_DIGITS_DEF  = 10;
  localparam int NUM_COLUMNS_DEF = 16;

  localparam int VALUE_W     = 32;
  localparam int STORE_DEPTH = 10;
  localparam int DIGIT_W     = 4;
  localparam int DIG_BITS    = STORE_DEPTH * DIGIT_W;
  localparam int IDX_W       = $clog2(STORE_DEPTH);
  localparam int CNT_W       = $clog2(VALUE_W);
  localparam int NIB_W       = 4;

  localparam int IN_TDATA_W  = 56;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 8;
  localparam int OUT_TUSER_W = 2;

  localparam logic [1:0] REQ_CMD    = 2'd0;
  localparam logic [1:0] REQ_CHAR   = 2'd1;
  localparam logic [1:0] REQ_INT    = 2'd2;
  localparam logic [1:0] REQ_CURSOR = 2'd3;

  localparam logic CFG_FIRST_LINE  = 1'b0;
  localparam logic CFG_SECOND_LINE = 1'b1;

  localparam logic [7:0] FIRST_LINE_RESET  = 8'd128;
  localparam logic [7:0] SECOND_LINE_RESET = 8'd192;

  localparam logic [NIB_W-1:0]   ASCII_DIGIT_HI = 4'h3;
  localparam logic [DIGIT_W-1:0] BCD_ADJ_MIN    = 4'd5;
  localparam logic [DIGIT_W-1:0] BCD_ADJ_ADD    = 4'd3;

  typedef logic [STORE_DEPTH-1:0][DIGIT_W-1:0] digits_t;

  typedef struct packed {
    logic busy;
    logic done;
  } bcd_status_t;

endpackage

// File: src/char_lcd_nibble_writer.sv
// Top level of the character LCD nibble writer.
`timescale 1ns / 1ps
// Turns requests into 4-bit LCD strobes, one result per strobe, high nibble
// first, last set on the final strobe of a request. Commands and character
// bytes take 2 strobes, a cursor move 2 strobes (or one error result when the
// column is past the last column), an integer print 2 strobes per digit. One
// request is handled at a time; the next is taken once the final result of
// the current one sits in the output register. An integer print first goes
// through the bit-serial BCD converter, which consumes one input bit per
// cycle, then through a leading zero scan that looks at one digit a cycle,
// and then sends the strobes of its digits.
module char_lcd_nibble_writer
  import clnw_pkg::*;
#(
  parameter int MAX_DIGITS  = MAX_DIGITS_DEF,
  parameter int NUM_COLUMNS = NUM_COLUMNS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic                   cfg_index,
  input  logic [7:0]             cfg_data,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // data_byte[7:0], int_value[39:8], row[40], column[48:41], zero fill
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // req_type[1:0]
  input  logic [IN_TUSER_W-1:0]  s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // nibble[3:0], zero fill
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // reg_select[0], error[1]
  output logic [OUT_TUSER_W-1:0] m_axis_tuser,
  output logic                   m_axis_tlast
);

  localparam int LIMIT = (MAX_DIGITS > STORE_DEPTH) ? STORE_DEPTH :
                         ((MAX_DIGITS < 1) ? 1 : MAX_DIGITS);
  localparam logic [IDX_W-1:0] LIMIT_IDX = IDX_W'(LIMIT);
  localparam logic [IDX_W-1:0] TOP_IDX   = IDX_W'(STORE_DEPTH - 1);
  localparam logic [7:0]       LAST_COL  = 8'(NUM_COLUMNS - 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CONV = 3'd1;
  localparam logic [2:0] ST_SCAN = 3'd2;
  localparam logic [2:0] ST_HI   = 3'd3;
  localparam logic [2:0] ST_LO   = 3'd4;
  localparam logic [2:0] ST_ERR  = 3'd5;

  logic [1:0]         req_type;
  logic [7:0]         data_byte;
  logic [VALUE_W-1:0] int_value;
  logic               row;
  logic [7:0]         column;

  logic [2:0]         state;
  logic [7:0]         first_addr;
  logic [7:0]         second_addr;
  logic               tx_rs;
  logic [7:0]         tx_byte;
  logic               final_byte;
  logic [IDX_W-1:0]   idx;
  logic               ovf;
  logic               out_valid;
  logic               out_rs;
  logic [NIB_W-1:0]   out_nib;
  logic               out_err;
  logic               out_last;

  logic               accept;
  logic               slot_free;
  logic               load_out;
  logic [7:0]         cur_addr;
  logic [IDX_W-1:0]   idx_dec;
  logic [DIGIT_W-1:0] scan_digit;
  logic [DIGIT_W-1:0] next_digit;
  logic               bcd_start;
  bcd_status_t        bcd_status;
  digits_t            bcd_digits;

  assign req_type  = s_axis_tuser;
  assign data_byte = s_axis_tdata[7:0];
  assign int_value = s_axis_tdata[39:8];
  assign row       = s_axis_tdata[40];
  assign column    = s_axis_tdata[48:41];

  assign s_axis_tready = (state == ST_IDLE);
  assign accept        = s_axis_tvalid & s_axis_tready;
  assign slot_free     = ~out_valid | m_axis_tready;
  assign load_out      = slot_free &&
                         ((state == ST_HI) || (state == ST_LO) || (state == ST_ERR));
  assign cur_addr      = (row ? second_addr : first_addr) + column;
  assign idx_dec       = idx - 1'b1;
  assign scan_digit    = bcd_digits[idx];
  assign next_digit    = bcd_digits[idx_dec];
  assign bcd_start     = accept && (req_type == REQ_INT);

  clnw_bcd u_bcd (
    .clk    (clk),
    .rst    (rst),
    .start  (bcd_start),
    .value  (int_value),
    .status (bcd_status),
    .digits (bcd_digits)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      out_valid   <= 1'b0;
      first_addr  <= FIRST_LINE_RESET;
      second_addr <= SECOND_LINE_RESET;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_FIRST_LINE:  first_addr  <= cfg_data;
          CFG_SECOND_LINE: second_addr <= cfg_data;
          default: ;
        endcase
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            final_byte <= 1'b1;
            case (req_type)
              REQ_CMD: begin
                tx_rs   <= 1'b0;
                tx_byte <= data_byte;
                state   <= ST_HI;
              end
              REQ_CHAR: begin
                tx_rs   <= 1'b1;
                tx_byte <= data_byte;
                state   <= ST_HI;
              end
              REQ_CURSOR: begin
                tx_rs   <= 1'b0;
                tx_byte <= cur_addr;
                state   <= (column > LAST_COL) ? ST_ERR : ST_HI;
              end
              default: begin
                state <= ST_CONV;
              end
            endcase
          end
        end
        ST_CONV: begin
          if (bcd_status.done) begin
            idx   <= TOP_IDX;
            ovf   <= 1'b0;
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (idx >= LIMIT_IDX) begin
            if (scan_digit != '0) ovf <= 1'b1;
            idx <= idx_dec;
          end else if ((scan_digit == '0) && !ovf && (idx != '0)) begin
            idx <= idx_dec;
          end else begin
            tx_rs      <= 1'b1;
            tx_byte    <= {ASCII_DIGIT_HI, scan_digit};
            final_byte <= (idx == '0);
            state      <= ST_HI;
          end
        end
        ST_HI: begin
          if (slot_free) begin
            out_rs    <= tx_rs;
            out_nib   <= tx_byte[7:4];
            out_err   <= 1'b0;
            out_last  <= 1'b0;
            state     <= ST_LO;
          end
        end
        ST_LO: begin
          if (slot_free) begin
            out_rs    <= tx_rs;
            out_nib   <= tx_byte[3:0];
            out_err   <= 1'b0;
            out_last  <= final_byte;
            if (final_byte) begin
              state <= ST_IDLE;
            end else begin
              idx        <= idx_dec;
              tx_byte    <= {ASCII_DIGIT_HI, next_digit};
              final_byte <= (idx_dec == '0);
              state      <= ST_HI;
            end
          end
        end
        ST_ERR: begin
          if (slot_free) begin
            out_rs    <= 1'b0;
            out_nib   <= '0;
            out_err   <= 1'b1;
            out_last  <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(OUT_TDATA_W - NIB_W){1'b0}}, out_nib};
  assign m_axis_tuser  = {out_err, out_rs};
  assign m_axis_tlast  = out_last;

endmodule

// File: src/clnw_bcd.sv
// Bit-serial binary to BCD converter (shift and add-3, one input bit per cycle).
`timescale 1ns / 1ps
module clnw_bcd
  import clnw_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [VALUE_W-1:0] value,
  output bcd_status_t        status,
  output digits_t            digits
);

  logic [VALUE_W-1:0]  sh;
  logic [CNT_W-1:0]    cnt;
  logic                busy;
  logic                done;
  digits_t             bcd;
  digits_t             adj;
  logic [DIG_BITS-1:0] adj_flat;

  always_comb begin
    for (int i = 0; i < STORE_DEPTH; i++) begin
      adj[i] = (bcd[i] >= BCD_ADJ_MIN) ? bcd[i] + BCD_ADJ_ADD : bcd[i];
    end
    adj_flat = adj;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        sh   <= value;
        bcd  <= '0;
      end else if (busy) begin
        sh  <= {sh[VALUE_W-2:0], 1'b0};
        bcd <= {adj_flat[DIG_BITS-2:0], sh[VALUE_W-1]};
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(VALUE_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign status.busy = busy;
  assign status.done = done;
  assign digits      = bcd;

endmodule

// File: src/clnw_checker.sv
// Port-level checker of the character LCD nibble writer, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module clnw_checker
  import clnw_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input logic [OUT_TUSER_W-1:0] m_axis_tuser,
  input logic                   m_axis_tlast
);

  `CLNW_ASSERT_ALWAYS(a_idle_after_reset, rst |=> !m_axis_tvalid, "result valid after reset")
  `CLNW_ASSERT(a_stall_holds, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "stalled transfer changed")
  `CLNW_ASSERT(a_error_is_last, m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tlast, "error result not last")
  `CLNW_ASSERT(a_error_empty, m_axis_tvalid && m_axis_tuser[1] |-> (m_axis_tdata == '0) && !m_axis_tuser[0], "error result carries a strobe")

endmodule

bind char_lcd_nibble_writer clnw_checker u_clnw_checker (.*);

// File: bench/tb_char_lcd_nibble_writer.sv
// Self-checking testbench for the character LCD nibble writer.
`timescale 1ns / 1ps
module tb_char_lcd_nibble_writer;
  import clnw_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int DRAIN_CYCLES  = 100;
  localparam int RANDOM_ITEMS  = 36;
  localparam int STALL_NONE     = 0;
  localparam int STALL_LIGHT    = 1;
  localparam int STALL_HEAVY    = 2;
  localparam int STALL_PERIODIC = 3;

  typedef struct packed {
    logic       reg_select;
    logic [3:0] nibble;
    logic       error;
    logic       last;
  } strobe_t;

  class lcd_strobe_tracker;
    logic [7:0] first_line  = FIRST_LINE_RESET;
    logic [7:0] second_line = SECOND_LINE_RESET;
    strobe_t    pending_strobes[$];
    int         requests[4] = '{0, 0, 0, 0};
    int         rejected  = 0;
    int         checked   = 0;
    int         failures  = 0;
    int         settings  = 1;

    function void set_line_address(logic index, logic [7:0] value);
      if (index == CFG_FIRST_LINE) first_line = value;
      else second_line = value;
    endfunction

    function void push_strobe(logic rs, logic [3:0] nib, logic err, logic fin);
      strobe_t s;
      s.reg_select = rs;
      s.nibble     = nib;
      s.error      = err;
      s.last       = fin;
      pending_strobes.push_back(s);
    endfunction

    function void push_byte(logic rs, logic [7:0] b, logic fin);
      push_strobe(rs, b[7:4], 1'b0, 1'b0);
      push_strobe(rs, b[3:0], 1'b0, fin);
    endfunction

    // Expand one accepted request into the strobes it must produce.
    function void note_request(logic [1:0] kind, logic [7:0] data, logic [31:0] value,
                               logic row, logic [7:0] column);
      logic [3:0]  digits[STORE_DEPTH];
      int          count;
      int          limit;
      logic [31:0] rest;
      logic [7:0]  addr;
      requests[kind]++;
      case (kind)
        REQ_CMD: begin
          push_byte(1'b0, data, 1'b1);
        end
        REQ_CHAR: begin
          push_byte(1'b1, data, 1'b1);
        end
        REQ_CURSOR: begin
          if (column > NUM_COLUMNS_DEF - 1) begin
            push_strobe(1'b0, 4'h0, 1'b1, 1'b1);
            rejected++;
          end else begin
            addr = (row ? second_line : first_line) + column;
            push_byte(1'b0, addr, 1'b1);
          end
        end
        default: begin
          limit = (MAX_DIGITS_DEF < STORE_DEPTH) ? MAX_DIGITS_DEF : STORE_DEPTH;
          rest  = value;
          count = 0;
          if (rest == 0) begin
            digits[0] = 4'd0;
            count     = 1;
          end else begin
            while (rest != 0 && count < limit) begin
              digits[count] = 4'(rest % 10);
              rest          = rest / 10;
              count++;
            end
          end
          for (int i = count; i > 0; i--)
            push_byte(1'b1, 8'd48 + 8'(digits[i-1]), i == 1);
        end
      endcase
    endfunction

    function void compare_field(string name, int want, int got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        failures++;
      end
    endfunction

    function void check_strobe(strobe_t got);
      strobe_t want;
      checked++;
      if (pending_strobes.size() == 0) begin
        $display("%0t: unexpected strobe, expected none, actual rs=%0d nib=%h err=%0d last=%0d",
                 $time, got.reg_select, got.nibble, got.error, got.last);
        failures++;
        return;
      end
      want = pending_strobes.pop_front();
      compare_field("reg_select", want.reg_select, got.reg_select);
      compare_field("nibble", want.nibble, got.nibble);
      compare_field("error", want.error, got.error);
      compare_field("last", want.last, got.last);
    endfunction

    function int pending_count();
      return pending_strobes.size();
    endfunction
  endclass

  logic                   clk           = 1'b0;
  logic                   rst           = 1'b1;
  logic                   cfg_we        = 1'b0;
  logic                   cfg_index     = CFG_FIRST_LINE;
  logic [7:0]             cfg_data      = 8'd0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic [IN_TUSER_W-1:0]  s_axis_tuser  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [OUT_TUSER_W-1:0] m_axis_tuser;
  logic                   m_axis_tlast;

  lcd_strobe_tracker tracker = new();
  int unsigned       cycle_count = 0;
  int                burst_left  = 0;
  int                stall_mode  = STALL_NONE;
  int                stall_epoch = 0;
  strobe_t           seen;

  char_lcd_nibble_writer dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      seen.reg_select = m_axis_tuser[0];
      seen.nibble     = m_axis_tdata[3:0];
      seen.error      = m_axis_tuser[1];
      seen.last       = m_axis_tlast;
      tracker.check_strobe(seen);
    end
    if (stall_epoch == 0) begin
      stall_mode  <= $urandom_range(STALL_NONE, STALL_PERIODIC);
      stall_epoch <= $urandom_range(16, 96);
    end else begin
      stall_epoch <= stall_epoch - 1;
    end
    case (stall_mode)
      STALL_NONE:  m_axis_tready <= 1'b1;
      STALL_LIGHT: m_axis_tready <= ($urandom_range(0, 3) != 0);
      STALL_HEAVY: m_axis_tready <= ($urandom_range(0, 3) == 0);
      default:     m_axis_tready <= ((cycle_count % 5) < 3);
    endcase
  end

  task automatic send_request(input logic [1:0] kind, input logic [7:0] data,
                              input logic [31:0] value, input logic row,
                              input logic [7:0] column);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {7'd0, column, row, value, data};
    do @(posedge clk); while (!s_axis_tready);
    tracker.note_request(kind, data, value, row, column);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 10);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(0, 12);
    end
  endtask

  task automatic drain;
    s_axis_tvalid <= 1'b0;
    while (tracker.pending_count() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_line_addresses(input logic [7:0] first, input logic [7:0] second);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_FIRST_LINE;
    cfg_data  <= first;
    @(posedge clk);
    cfg_index <= CFG_SECOND_LINE;
    cfg_data  <= second;
    @(posedge clk);
    cfg_we <= 1'b0;
    tracker.set_line_address(CFG_FIRST_LINE, first);
    tracker.set_line_address(CFG_SECOND_LINE, second);
    tracker.settings++;
  endtask

  function automatic logic [31:0] pick_value();
    logic [31:0] p;
    p = 32'd1;
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 9);
      1: return $urandom_range(10, 99999);
      2: return $urandom;
      3: begin
        repeat ($urandom_range(1, 9)) p = p * 10;
        return p - $urandom_range(0, 1);
      end
      4: return 32'hFFFF_FFFF - $urandom_range(0, 5);
      default: return 32'd0;
    endcase
  endfunction

  task automatic run_random(input int count);
    logic [7:0] column;
    repeat (count) begin
      column = ($urandom_range(0, 6) != 0) ? 8'($urandom_range(0, NUM_COLUMNS_DEF - 1))
                                           : 8'($urandom_range(NUM_COLUMNS_DEF, 255));
      send_request(2'($urandom_range(0, 3)), 8'($urandom), pick_value(),
                   1'($urandom_range(0, 1)), column);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_request(REQ_CMD,    8'h00, 32'hFFFF_FFFF, 1'b1, 8'hFF);
    send_request(REQ_CMD,    8'hFF, 32'd0,         1'b0, 8'h00);
    send_request(REQ_CHAR,   8'h00, 32'hFFFF_FFFF, 1'b1, 8'hFF);
    send_request(REQ_CHAR,   8'hFF, 32'd0,         1'b0, 8'h00);
    send_request(REQ_CHAR,   8'h5A, 32'h1234_5678, 1'b1, 8'h20);
    send_request(REQ_INT,    8'hFF, 32'd0,         1'b1, 8'hFF);
    send_request(REQ_INT,    8'h00, 32'd9,         1'b0, 8'h00);
    send_request(REQ_INT,    8'h00, 32'd10,        1'b0, 8'h00);
    send_request(REQ_INT,    8'h00, 32'd1000000000, 1'b0, 8'h00);
    send_request(REQ_INT,    8'h00, 32'd999999999, 1'b0, 8'h00);
    send_request(REQ_INT,    8'h00, 32'hFFFF_FFFF, 1'b0, 8'h00);
    send_request(REQ_CURSOR, 8'hFF, 32'hFFFF_FFFF, 1'b0, 8'd0);
    send_request(REQ_CURSOR, 8'h00, 32'd0,         1'b1, 8'd15);
    send_request(REQ_CURSOR, 8'h00, 32'd0,         1'b0, 8'd15);
    send_request(REQ_CURSOR, 8'h00, 32'd0,         1'b0, 8'd16);
    send_request(REQ_CURSOR, 8'h00, 32'd0,         1'b1, 8'd255);
    drain();

    // base address near the top: cursor addresses wrap past 255
    write_line_addresses(8'hFF, 8'hFF);
    send_request(REQ_CURSOR, 8'h00, 32'd0, 1'b0, 8'd0);
    send_request(REQ_CURSOR, 8'h00, 32'd0, 1'b0, 8'd1);
    send_request(REQ_CURSOR, 8'h00, 32'd0, 1'b1, 8'd15);
    run_random(RANDOM_ITEMS);
    drain();

    write_line_addresses(8'h00, 8'h00);
    run_random(RANDOM_ITEMS);
    drain();

    write_line_addresses(8'($urandom), 8'($urandom));
    run_random(RANDOM_ITEMS);
    drain();

    write_line_addresses(8'hF0, 8'h0F);
    run_random(RANDOM_ITEMS);
    drain();

    write_line_addresses(FIRST_LINE_RESET, SECOND_LINE_RESET);
    run_random(RANDOM_ITEMS);
    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d command, %0d character, %0d integer, %0d cursor requests",
             tracker.requests[REQ_CMD], tracker.requests[REQ_CHAR],
             tracker.requests[REQ_INT], tracker.requests[REQ_CURSOR]);
    $display("checked %0d strobes, %0d rejected cursor moves, %0d address settings",
             tracker.checked, tracker.rejected, tracker.settings);
    if (tracker.failures == 0 && tracker.pending_count() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
